// File: sv/scba_pkg.sv
// Shared constants, defaults and codes of the size-class block allocator.
package scba_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 12;
    localparam int SIZE_W     = 16;
    localparam int LINK_W     = ADDR_W + 1;
    localparam int LINK_DEPTH = 1 << ADDR_W;

    // Parameter defaults
    localparam int NUM_CLASSES_DEF  = 16;
    localparam int CHUNK_BLOCKS_DEF = 256;
    localparam int ARENA_CHUNKS_DEF = 16;
    localparam int BLOCK_SHIFT_DEF  = 3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_BIG  = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    // Request operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// File: sv/scba_req_if.sv
// Request channel: allocate or free beat with valid/ready handshake.
interface scba_req_if
    import scba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_addr;

    modport source (output valid, output op, output size_bytes, output block_addr,
                    input ready);
    modport sink   (input valid, input op, input size_bytes, input block_addr,
                    output ready);
endinterface

// File: sv/scba_rsp_if.sv
// Response channel: granted block index and status with valid/ready handshake.
interface scba_rsp_if
    import scba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_addr;
    logic [1:0]        status;

    modport source (output valid, output granted_addr, output status, input ready);
    modport sink   (input valid, input granted_addr, input status, output ready);
endinterface

// File: sv/size_class_block_allocator.sv
// Size-class block allocator top level: request sequencer over head and link memories.
//
// One request is taken at a time and answered by exactly one response beat. A free, a
// rejected request (zero size or more than NUM_CLASSES blocks) and an allocate served
// from the open chunk go from S_HEAD straight back to S_IDLE; an allocate that pops a free
// list passes S_LINK on the way, and one that spills the open chunk's leftover onto a
// class list passes S_LEFT. These states exist because the class-head memory and the
// 4096-entry link memory have registered read data: the head is read in the accept cycle,
// and a list pop or a spill needs one further dependent read. A new request is accepted
// while the previous response still waits in the output register; the sequencer stalls
// only when a second response is ready and the output register is still full. List heads
// start empty through per-class valid flops, so no clearing pass follows reset.
module size_class_block_allocator
    import scba_pkg::*;
#(
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
    parameter int CHUNK_BLOCKS = CHUNK_BLOCKS_DEF,
    parameter int ARENA_CHUNKS = ARENA_CHUNKS_DEF,
    parameter int BLOCK_SHIFT  = BLOCK_SHIFT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    scba_req_if.sink   req,
    scba_rsp_if.source rsp
);
    localparam int CLS_W  = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
    localparam int BLK_W  = $clog2(NUM_CLASSES + 1);
    localparam int LEFT_W = $clog2(CHUNK_BLOCKS + 1);
    localparam int CHK_W  = $clog2(ARENA_CHUNKS + 1);
    localparam int CMP_W  = BLK_W > LEFT_W ? BLK_W : LEFT_W;
    localparam int SUM_W  = SIZE_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HEAD = 4'b0010,
        S_LINK = 4'b0100,
        S_LEFT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Request registers
    logic              op_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [BLK_W-1:0]  blocks_reg;
    logic [ADDR_W-1:0] addr_reg;
    status_t           rstat_reg;
    logic [ADDR_W-1:0] gnt_reg, gnt_next;

    // Carve state
    logic [ADDR_W-1:0]      carve_ptr_reg, carve_ptr_next;
    logic [LEFT_W-1:0]      carve_left_reg, carve_left_next;
    logic [CHK_W-1:0]       chunks_reg, chunks_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [NUM_CLASSES-1:0] head_vld_reg, head_vld_next;

    // Output register
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    status_t           out_stat_reg;

    // Memory ports
    logic              head_we;
    logic [CLS_W-1:0]  head_waddr, head_raddr;
    logic [ADDR_W-1:0] head_wdata, head_rdata;
    logic              link_we;
    logic [ADDR_W-1:0] link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_rdata;

    // Decode of the incoming size
    logic [SUM_W-1:0] in_sum, in_blocks, in_blk_m1;
    logic             in_big;
    logic             in_accept;
    logic [CLS_W-1:0] in_cls;

    // Sequencer helpers
    logic             slot_free;
    logic             res_load;
    logic [ADDR_W-1:0] res_addr;
    status_t          res_stat;
    logic [CMP_W-1:0] left_m1;
    logic [CLS_W-1:0] left_cls;
    logic             need_chunk;
    logic             head_cur_vld;
    logic             spill;
    logic             arena_out;

    assign in_sum    = {1'b0, req.size_bytes} + SUM_W'((1 << BLOCK_SHIFT) - 1);
    assign in_blocks = in_sum >> BLOCK_SHIFT;
    assign in_blk_m1 = in_blocks - SUM_W'(1);
    assign in_cls    = in_blk_m1[CLS_W-1:0];
    assign in_big    = in_blocks > SUM_W'(NUM_CLASSES);
    assign in_accept = req.valid && req.ready;

    assign req.ready = (state_reg == S_IDLE);

    assign slot_free    = !out_valid_reg || rsp.ready;
    assign left_m1      = CMP_W'(carve_left_reg) - CMP_W'(1);
    assign left_cls     = left_m1[CLS_W-1:0];
    assign need_chunk   = CMP_W'(blocks_reg) > CMP_W'(carve_left_reg);
    assign head_cur_vld = head_vld_reg[cls_reg];
    assign spill        = need_chunk && (carve_left_reg != '0);
    assign arena_out    = chunks_reg >= CHK_W'(ARENA_CHUNKS);

    // Class-head memory
    scba_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_CLASSES)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    // Per-block link memory
    scba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Sequence one request: read, modify, write back
    always_comb
    begin
        state_next      = state_reg;
        gnt_next        = gnt_reg;
        carve_ptr_next  = carve_ptr_reg;
        carve_left_next = carve_left_reg;
        chunks_next     = chunks_reg;
        base_next       = base_reg;
        head_vld_next   = head_vld_reg;
        head_we         = 1'b0;
        head_waddr      = cls_reg;
        head_wdata      = addr_reg;
        head_raddr      = cls_reg;
        link_we         = 1'b0;
        link_waddr      = addr_reg;
        link_wdata      = {head_cur_vld, head_rdata};
        link_raddr      = gnt_reg;
        res_load        = 1'b0;
        res_addr        = '0;
        res_stat        = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                head_raddr = in_cls;
                if (in_accept)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (rstat_reg != ST_OK)
                begin
                    // Rejected request: report only
                    if (slot_free)
                    begin
                        res_load   = 1'b1;
                        res_stat   = rstat_reg;
                        state_next = S_IDLE;
                    end
                end
                else if (op_reg == OP_FREE)
                begin
                    // Push the freed block onto its class list
                    if (slot_free)
                    begin
                        link_we                = 1'b1;
                        head_we                = 1'b1;
                        head_vld_next[cls_reg] = 1'b1;
                        res_load               = 1'b1;
                        state_next             = S_IDLE;
                    end
                end
                else if (head_cur_vld)
                begin
                    // Pop: fetch the head's link next
                    gnt_next   = head_rdata;
                    link_raddr = head_rdata;
                    state_next = S_LINK;
                end
                else if (spill)
                begin
                    // Fetch the head of the leftover's class
                    head_raddr = left_cls;
                    state_next = S_LEFT;
                end
                else if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LINK:
            begin
                if (slot_free)
                begin
                    head_we                = 1'b1;
                    head_wdata             = link_rdata[ADDR_W-1:0];
                    head_vld_next[cls_reg] = link_rdata[ADDR_W];
                    res_load               = 1'b1;
                    res_addr               = gnt_reg;
                    state_next             = S_IDLE;
                end
            end
            S_LEFT:
            begin
                head_raddr = left_cls;
                if (slot_free)
                begin
                    // Push the open chunk's leftover
                    link_we                 = 1'b1;
                    link_waddr              = carve_ptr_reg;
                    link_wdata              = {head_vld_reg[left_cls], head_rdata};
                    head_we                 = 1'b1;
                    head_waddr              = left_cls;
                    head_wdata              = carve_ptr_reg;
                    head_vld_next[left_cls] = 1'b1;
                    res_load                = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Carve from the open chunk, or open the next one, or report out of memory
        if (res_load && (rstat_reg == ST_OK) && (op_reg == OP_ALLOC)
            && (state_reg != S_LINK))
        begin
            if (need_chunk)
            begin
                if (arena_out)
                begin
                    carve_left_next = '0;
                    res_stat        = ST_OOM;
                end
                else
                begin
                    res_addr        = base_reg;
                    carve_ptr_next  = base_reg + ADDR_W'(blocks_reg);
                    carve_left_next = LEFT_W'(CHUNK_BLOCKS) - LEFT_W'(blocks_reg);
                    chunks_next     = chunks_reg + CHK_W'(1);
                    base_next       = base_reg + ADDR_W'(CHUNK_BLOCKS);
                end
            end
            else
            begin
                res_addr        = carve_ptr_reg;
                carve_ptr_next  = carve_ptr_reg + ADDR_W'(blocks_reg);
                carve_left_next = carve_left_reg - LEFT_W'(blocks_reg);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            carve_ptr_reg  <= '0;
            carve_left_reg <= '0;
            chunks_reg     <= '0;
            base_reg       <= '0;
            head_vld_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            carve_ptr_reg  <= carve_ptr_next;
            carve_left_reg <= carve_left_next;
            chunks_reg     <= chunks_next;
            base_reg       <= base_next;
            head_vld_reg   <= head_vld_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request and result payload
    always_ff @(posedge clk)
    begin
        gnt_reg <= gnt_next;
        if (in_accept)
        begin
            op_reg     <= req.op;
            cls_reg    <= in_cls;
            blocks_reg <= in_blocks[BLK_W-1:0];
            addr_reg   <= req.block_addr;
            if (req.size_bytes == '0)
            begin
                rstat_reg <= ST_ZERO;
            end
            else if (in_big)
            begin
                rstat_reg <= ST_BIG;
            end
            else
            begin
                rstat_reg <= ST_OK;
            end
        end
        if (res_load)
        begin
            out_addr_reg <= res_addr;
            out_stat_reg <= res_stat;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_addr = out_addr_reg;
    assign rsp.status       = out_stat_reg;

    // Checks
    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || rsp.ready))
        else $error("result loaded over a waiting beat");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_HEAD))
        else $error("request accepted without head lookup");

    a_gnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.granted_addr != '0)) |-> (rsp.status == ST_OK))
        else $error("nonzero address with failing status");

    a_chunks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunks_reg <= CHK_W'(ARENA_CHUNKS))
        else $error("more chunks opened than the arena holds");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        carve_left_reg <= LEFT_W'(CHUNK_BLOCKS))
        else $error("open chunk larger than a chunk");

endmodule

// File: sv/scba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: tb/sv/tb_size_class_block_allocator.sv
// Self-checking testbench for the size-class block allocator.
`timescale 1ns / 1ps

module tb_size_class_block_allocator
    import scba_pkg::*;
;

    // Expected response beat
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } grant_t;

    // A piece handed out and not yet given back
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } held_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;

    scba_req_if req_bus ();
    scba_rsp_if rsp_bus ();

    size_class_block_allocator #(
        .NUM_CLASSES  (NUM_CLASSES_DEF),
        .CHUNK_BLOCKS (CHUNK_BLOCKS_DEF),
        .ARENA_CHUNKS (ARENA_CHUNKS_DEF),
        .BLOCK_SHIFT  (BLOCK_SHIFT_DEF)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Allocator state as the testbench sees it
    logic [LINK_W-1:0] class_head [NUM_CLASSES_DEF];
    logic [LINK_W-1:0] link_word  [LINK_DEPTH];
    logic [ADDR_W-1:0] carve_next;
    logic [8:0]        carve_room;
    logic [4:0]        chunks_open;

    grant_t expected_grants [$];
    held_t  held_blocks [$];

    int error_count = 0;
    int sent_count  = 0;
    int ok_count    = 0;
    int oom_count   = 0;
    int reject_count = 0;
    int pop_count   = 0;
    int spill_count = 0;

    always #4 clk = ~clk;

    // Push a block onto the head of a class list
    function automatic void push_free(int unsigned cls, logic [ADDR_W-1:0] addr);
        link_word[addr] = class_head[cls];
        class_head[cls] = {1'b1, addr};
    endfunction

    // Compute the response of one request and advance the state
    function automatic grant_t predict_request(logic op, logic [SIZE_W-1:0] size,
                                               logic [ADDR_W-1:0] addr);
        grant_t      g;
        int unsigned blocks;
        int unsigned cls;
        g.addr   = '0;
        g.status = ST_OK;
        blocks = (32'(size) + (1 << BLOCK_SHIFT_DEF) - 1) >> BLOCK_SHIFT_DEF;
        if (size == '0)
            g.status = ST_ZERO;
        else if (blocks > NUM_CLASSES_DEF)
            g.status = ST_BIG;
        else
        begin
            cls = blocks - 1;
            if (op == OP_FREE)
                push_free(cls, addr);
            else if (class_head[cls][ADDR_W])
            begin
                g.addr = class_head[cls][ADDR_W-1:0];
                class_head[cls] = link_word[g.addr];
                pop_count++;
            end
            else
            begin
                // When the request does not fit, spill the leftover and open the next chunk; then carve
                if (blocks > carve_room)
                begin
                    if (carve_room != 0)
                    begin
                        push_free(carve_room - 1, carve_next);
                        spill_count++;
                    end
                    carve_room = '0;
                    if (chunks_open >= ARENA_CHUNKS_DEF)
                        g.status = ST_OOM;
                    else
                    begin
                        carve_next  = ADDR_W'(chunks_open * CHUNK_BLOCKS_DEF);
                        carve_room  = 9'(CHUNK_BLOCKS_DEF);
                        chunks_open = chunks_open + 1'b1;
                    end
                end
                if (g.status == ST_OK)
                begin
                    g.addr     = carve_next;
                    carve_next = carve_next + ADDR_W'(blocks);
                    carve_room = carve_room - 9'(blocks);
                end
            end
        end
        return g;
    endfunction

    // Send one request beat; returns at a falling edge with valid still high
    task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] addr);
        grant_t g;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        g = predict_request(op, size, addr);
        expected_grants.push_back(g);
        sent_count++;
        case (g.status)
            ST_OK:   ok_count++;
            ST_OOM:  oom_count++;
            default: reject_count++;
        endcase
        if (op == OP_ALLOC && g.status == ST_OK)
            held_blocks.push_back('{addr: g.addr, size: size});
        req_bus.valid      <= 1'b1;
        req_bus.op         <= op;
        req_bus.size_bytes <= size;
        req_bus.block_addr <= addr;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One request of a realistic mix: allocate, give back, stray free, reject
    task automatic send_random_request();
        int    pick;
        int    idx;
        held_t h;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(OP_ALLOC, SIZE_W'($urandom_range(1, 16)), ADDR_W'($urandom));
            else
                send_request(OP_ALLOC, SIZE_W'($urandom_range(1, 128)), ADDR_W'($urandom));
        end
        else if (pick < 80 && held_blocks.size() != 0)
        begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            h = held_blocks[idx];
            // keep it listed now and then, so it gets freed twice
            if ($urandom_range(0, 9) != 0)
                held_blocks.delete(idx);
            send_request(OP_FREE, h.size, h.addr);
        end
        else if (pick < 90)
            send_request(OP_FREE, SIZE_W'($urandom_range(1, 128)), ADDR_W'($urandom));
        else if (pick < 95)
            send_request(1'($urandom), '0, ADDR_W'($urandom));
        else
            send_request(1'($urandom), SIZE_W'($urandom_range(129, 65535)),
                         ADDR_W'($urandom));
    endtask

    // Zero sizes and oversize requests on both operations
    task automatic test_rejected_sizes();
        send_request(OP_ALLOC, '0, '0);
        send_request(OP_FREE, '0, '1);
        send_request(OP_ALLOC, 16'd129, 12'd7);
        send_request(OP_FREE, 16'd129, 12'd9);
        send_request(OP_FREE, '1, '1);
        send_request(OP_ALLOC, 16'hAAAA, 12'h555);
        send_request(OP_ALLOC, 16'h5555, 12'hAAA);
    endtask

    // Carve from the first chunk, then recycle through the class lists
    task automatic test_list_reuse();
        send_request(OP_ALLOC, 16'd1, '1);
        send_request(OP_ALLOC, 16'd8, '0);
        send_request(OP_ALLOC, 16'd9, '0);
        send_request(OP_ALLOC, 16'd128, '0);
        send_request(OP_FREE, 16'd128, 12'd4);
        send_request(OP_ALLOC, 16'd121, '0);
        send_request(OP_FREE, 16'd1, '1);
        send_request(OP_FREE, 16'd8, 12'd0);
        send_request(OP_ALLOC, 16'd1, '0);
        send_request(OP_ALLOC, 16'd7, '0);
        send_request(OP_ALLOC, 16'd2, '0);
        send_request(OP_FREE, 16'd24, 12'hAAA);
        send_request(OP_FREE, 16'd17, 12'h555);
        send_request(OP_ALLOC, 16'd20, '0);
        send_request(OP_ALLOC, 16'd24, '0);
        send_request(OP_ALLOC, 16'd128, '0);
    endtask

    // Mixed traffic with random gaps on both sides
    task automatic test_random_traffic(input int count);
        repeat (count)
            send_random_request();
    endtask

    // Large allocations until the arena runs dry, leftovers spilling on the way
    task automatic test_arena_exhaustion();
        int tries;
        tries = 0;
        while (oom_count < 8 && tries < 350)
        begin
            if ($urandom_range(0, 7) == 0)
                send_random_request();
            else
                send_request(OP_ALLOC, SIZE_W'($urandom_range(65, 128)), ADDR_W'($urandom));
            tries++;
        end
    endtask

    // Back-to-back traffic after exhaustion, no stalls on either side
    task automatic test_steady_drain(input int count);
        calm = 1'b1;
        repeat (count)
            send_random_request();
    endtask

    // Compare each response beat with the oldest expectation
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_grants.size() == 0)
            begin
                $error("unexpected response beat: granted_addr %0d status %0d",
                       rsp_bus.granted_addr, rsp_bus.status);
                error_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (rsp_bus.granted_addr !== want.addr)
                begin
                    $error("granted_addr mismatch: expected %0d, actual %0d",
                           want.addr, rsp_bus.granted_addr);
                    error_count++;
                end
                if (rsp_bus.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_bus.status);
                    error_count++;
                end
            end
        end
    end

    // Response side: ready with random stall bursts
    initial
    begin
        int hold;
        hold = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                rsp_bus.ready <= 1'b1;
            else if (hold > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 8) - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Hard stop if the run hangs
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.op         <= OP_ALLOC;
        req_bus.size_bytes <= '0;
        req_bus.block_addr <= '0;
        for (int i = 0; i < NUM_CLASSES_DEF; i++)
            class_head[i] = '0;
        for (int i = 0; i < LINK_DEPTH; i++)
            link_word[i] = '0;
        carve_next  = '0;
        carve_room  = '0;
        chunks_open = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_rejected_sizes();
        test_list_reuse();
        test_random_traffic(180);
        test_arena_exhaustion();
        test_steady_drain(60);

        // Drain outstanding responses, then let the pipeline settle
        req_bus.valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d requests: %0d granted or freed, %0d out of memory, %0d rejected",
                 sent_count, ok_count, oom_count, reject_count);
        $display("List pops %0d, chunk leftovers spilled %0d, chunks opened %0d",
                 pop_count, spill_count, chunks_open);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
sv/scba_pkg.sv
sv/scba_req_if.sv
sv/scba_rsp_if.sv
sv/scba_ram.sv
sv/size_class_block_allocator.sv
tb/sv/tb_size_class_block_allocator.sv
